/* rtl/core/ccpl_pkg.sv */
package ccpl_pkg;

    localparam int CFG_DIM_W   = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PIX_W       = 32;
    localparam int RUN_W       = 25;
    localparam int NUM_PARTS   = 5;
    localparam int TDATA_OUT_W = 64;
    localparam int TUSER_OUT_W = 3;

    // result order within one item
    localparam int PART_TOP    = 0;
    localparam int PART_LEFT   = 1;
    localparam int PART_COPY   = 2;
    localparam int PART_RIGHT  = 3;
    localparam int PART_BOTTOM = 4;

    // bit positions in the output tuser
    localparam int TU_IS_FILL  = 0;
    localparam int TU_LINE_END = 1;
    localparam int TU_LAST     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 3'd0,
        REG_SOURCE_HEIGHT = 3'd1,
        REG_TARGET_WIDTH  = 3'd2,
        REG_TARGET_HEIGHT = 3'd3,
        REG_FILL_VALUE    = 3'd4,
        REG_NARROW_PIXELS = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0]     pixel;
        logic [NUM_PARTS-1:0] parts;
        logic                 copy_le;
        logic                 copy_fe;
        logic                 right_fe;
    } entry_t;

endpackage

/* rtl/core/ccpl_geom.sv */
module ccpl_geom #(
    parameter int MAX_DIM = 4096,
    localparam int DW = $clog2(MAX_DIM + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ccpl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ccpl_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [DW-1:0]                     sw_cl,
    output logic [DW-1:0]                     sh_cl,
    output logic [DW-1:0]                     in_c,
    output logic [DW-1:0]                     c_end,
    output logic [DW-1:0]                     in_r,
    output logic [DW-1:0]                     r_end,
    output logic [DW-1:0]                     sw_last,
    output logic [DW-1:0]                     sh_last,
    output logic                              top_nz,
    output logic                              left_nz,
    output logic                              right_nz,
    output logic                              bottom_nz,
    output logic [ccpl_pkg::RUN_W-1:0]        left_run,
    output logic [ccpl_pkg::RUN_W-1:0]        right_run,
    output logic [ccpl_pkg::RUN_W-1:0]        top_run,
    output logic [ccpl_pkg::RUN_W-1:0]        bottom_run,
    output logic [ccpl_pkg::PIX_W-1:0]        fill_value,
    output logic                              narrow_pixels
);

    localparam int CMPW = (DW > ccpl_pkg::CFG_DIM_W) ? DW : ccpl_pkg::CFG_DIM_W;
    localparam int PRW  = (2 * DW > ccpl_pkg::RUN_W) ? 2 * DW : ccpl_pkg::RUN_W;

    logic [ccpl_pkg::CFG_DIM_W-1:0] sw_reg, sh_reg, tw_reg, th_reg;
    logic [ccpl_pkg::PIX_W-1:0]     fill_reg;
    logic                           narrow_reg;

    logic [DW-1:0] tw_cl, th_cl;
    logic          crop_c, pad_c, crop_r, pad_r;
    logic [DW-1:0] ad_c, ad_r, half_c, half_r;

    logic [DW-1:0] in_c_reg, in_c_next, c_end_reg, c_end_next;
    logic [DW-1:0] in_r_reg, in_r_next, r_end_reg, r_end_next;
    logic [DW-1:0] left_reg, left_next, right_reg, right_next;
    logic [DW-1:0] top_reg, top_next, bottom_reg, bottom_next;
    logic [DW-1:0] twg_reg, twg_next, sw_last_reg, sw_last_next, sh_last_reg, sh_last_next;
    logic [PRW-1:0] prod_top, prod_bottom;
    logic [ccpl_pkg::RUN_W-1:0] top_run_reg, top_run_next, bottom_run_reg, bottom_run_next;

    function automatic logic [DW-1:0] clamp_dim(input logic [ccpl_pkg::CFG_DIM_W-1:0] v);
        logic [CMPW-1:0] ve;
        ve = CMPW'(v);
        if (v == '0)
            return DW'(1);
        else if (ve > CMPW'(MAX_DIM))
            return DW'(MAX_DIM);
        else
            return DW'(ve);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg     <= ccpl_pkg::CFG_DIM_W'(1);
            sh_reg     <= ccpl_pkg::CFG_DIM_W'(1);
            tw_reg     <= ccpl_pkg::CFG_DIM_W'(1);
            th_reg     <= ccpl_pkg::CFG_DIM_W'(1);
            fill_reg   <= '0;
            narrow_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (ccpl_pkg::cfg_reg_t'(cfg_index))
                ccpl_pkg::REG_SOURCE_WIDTH:  sw_reg     <= cfg_data[ccpl_pkg::CFG_DIM_W-1:0];
                ccpl_pkg::REG_SOURCE_HEIGHT: sh_reg     <= cfg_data[ccpl_pkg::CFG_DIM_W-1:0];
                ccpl_pkg::REG_TARGET_WIDTH:  tw_reg     <= cfg_data[ccpl_pkg::CFG_DIM_W-1:0];
                ccpl_pkg::REG_TARGET_HEIGHT: th_reg     <= cfg_data[ccpl_pkg::CFG_DIM_W-1:0];
                ccpl_pkg::REG_FILL_VALUE:    fill_reg   <= cfg_data[ccpl_pkg::PIX_W-1:0];
                ccpl_pkg::REG_NARROW_PIXELS: narrow_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        sw_cl  = clamp_dim(sw_reg);
        sh_cl  = clamp_dim(sh_reg);
        tw_cl  = clamp_dim(tw_reg);
        th_cl  = clamp_dim(th_reg);
        crop_c = sw_cl > tw_cl;
        pad_c  = tw_cl > sw_cl;
        crop_r = sh_cl > th_cl;
        pad_r  = th_cl > sh_cl;
        ad_c   = crop_c ? sw_cl - tw_cl : tw_cl - sw_cl;
        ad_r   = crop_r ? sh_cl - th_cl : th_cl - sh_cl;
        half_c = ad_c >> 1;
        half_r = ad_r >> 1;

        in_c_next    = crop_c ? half_c : '0;
        c_end_next   = crop_c ? half_c + tw_cl - DW'(1) : sw_cl - DW'(1);
        left_next    = pad_c ? half_c : '0;
        right_next   = pad_c ? half_c + DW'(ad_c[0]) : '0;
        in_r_next    = crop_r ? half_r : '0;
        r_end_next   = crop_r ? half_r + th_cl - DW'(1) : sh_cl - DW'(1);
        top_next     = pad_r ? half_r : '0;
        bottom_next  = pad_r ? half_r + DW'(ad_r[0]) : '0;
        twg_next     = tw_cl;
        sw_last_next = sw_cl - DW'(1);
        sh_last_next = sh_cl - DW'(1);

        prod_top        = PRW'(top_reg) * PRW'(twg_reg);
        prod_bottom     = PRW'(bottom_reg) * PRW'(twg_reg);
        top_run_next    = prod_top[ccpl_pkg::RUN_W-1:0];
        bottom_run_next = prod_bottom[ccpl_pkg::RUN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_c_reg       <= '0;
            c_end_reg      <= '0;
            in_r_reg       <= '0;
            r_end_reg      <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            top_reg        <= '0;
            bottom_reg     <= '0;
            twg_reg        <= DW'(1);
            sw_last_reg    <= '0;
            sh_last_reg    <= '0;
            top_run_reg    <= '0;
            bottom_run_reg <= '0;
        end
        else
        begin
            in_c_reg       <= in_c_next;
            c_end_reg      <= c_end_next;
            in_r_reg       <= in_r_next;
            r_end_reg      <= r_end_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            top_reg        <= top_next;
            bottom_reg     <= bottom_next;
            twg_reg        <= twg_next;
            sw_last_reg    <= sw_last_next;
            sh_last_reg    <= sh_last_next;
            top_run_reg    <= top_run_next;
            bottom_run_reg <= bottom_run_next;
        end
    end

    assign in_c          = in_c_reg;
    assign c_end         = c_end_reg;
    assign in_r          = in_r_reg;
    assign r_end         = r_end_reg;
    assign sw_last       = sw_last_reg;
    assign sh_last       = sh_last_reg;
    assign top_nz        = top_reg != '0;
    assign left_nz       = left_reg != '0;
    assign right_nz      = right_reg != '0;
    assign bottom_nz     = bottom_reg != '0;
    assign left_run      = ccpl_pkg::RUN_W'(left_reg);
    assign right_run     = ccpl_pkg::RUN_W'(right_reg);
    assign top_run       = top_run_reg;
    assign bottom_run    = bottom_run_reg;
    assign fill_value    = fill_reg;
    assign narrow_pixels = narrow_reg;

endmodule

/* rtl/core/ccpl_front.sv */
module ccpl_front #(
    parameter int MAX_DIM = 4096,
    localparam int DW = $clog2(MAX_DIM + 1),
    localparam int PW = $clog2(MAX_DIM)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ccpl_pkg::PIX_W-1:0]    in_pixel,
    input  logic [DW-1:0]                 sw_cl,
    input  logic [DW-1:0]                 sh_cl,
    input  logic [DW-1:0]                 in_c,
    input  logic [DW-1:0]                 c_end,
    input  logic [DW-1:0]                 in_r,
    input  logic [DW-1:0]                 r_end,
    input  logic [DW-1:0]                 sw_last,
    input  logic [DW-1:0]                 sh_last,
    input  logic                          top_nz,
    input  logic                          left_nz,
    input  logic                          right_nz,
    input  logic                          bottom_nz,
    input  logic                          q_full,
    output logic                          q_push,
    output ccpl_pkg::entry_t              q_entry
);

    logic [PW-1:0] col_reg, col_next, row_reg, row_next;
    logic          s1_valid_reg, s1_valid_next;
    logic [ccpl_pkg::PIX_W-1:0] s1_pix_reg;
    logic [PW-1:0] s1_col_reg, s1_row_reg;
    logic [DW-1:0] col_inc, row_inc, c_x, r_x;
    logic          accept, s1_go, need_push;
    logic          row_kept, col_kept, kept, first_col, last_col, last_row, last_src;

    assign accept = in_valid && in_ready;
    assign col_inc = DW'(col_reg) + DW'(1);
    assign row_inc = DW'(row_reg) + DW'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= sw_cl)
            begin
                col_next = '0;
                row_next = (row_inc >= sh_cl) ? '0 : PW'(row_inc);
            end
            else
            begin
                col_next = PW'(col_inc);
            end
        end
    end

    // classify the held item against the registered geometry
    always_comb
    begin
        c_x       = DW'(s1_col_reg);
        r_x       = DW'(s1_row_reg);
        row_kept  = (r_x >= in_r) && (r_x <= r_end);
        col_kept  = (c_x >= in_c) && (c_x <= c_end);
        kept      = row_kept && col_kept;
        first_col = c_x == in_c;
        last_col  = c_x == c_end;
        last_row  = r_x == r_end;
        last_src  = (r_x == sh_last) && (c_x == sw_last);

        q_entry.pixel                        = s1_pix_reg;
        q_entry.parts[ccpl_pkg::PART_TOP]    = kept && (r_x == in_r) && first_col && top_nz;
        q_entry.parts[ccpl_pkg::PART_LEFT]   = kept && first_col && left_nz;
        q_entry.parts[ccpl_pkg::PART_COPY]   = kept;
        q_entry.parts[ccpl_pkg::PART_RIGHT]  = kept && last_col && right_nz;
        q_entry.parts[ccpl_pkg::PART_BOTTOM] = last_src && bottom_nz;
        q_entry.copy_le  = last_col && !right_nz;
        q_entry.copy_fe  = last_col && !right_nz && last_row && !bottom_nz;
        q_entry.right_fe = last_row && !bottom_nz;

        need_push = q_entry.parts != '0;
        s1_go     = !need_push || !q_full;
        q_push    = s1_valid_reg && need_push && !q_full;
        in_ready  = !s1_valid_reg || s1_go;
        s1_valid_next = accept ? 1'b1 : (s1_valid_reg && !s1_go);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= in_pixel;
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
        end
    end

endmodule

/* rtl/core/ccpl_queue.sv */
module ccpl_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ccpl_pkg::entry_t push_entry,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output ccpl_pkg::entry_t head
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    ccpl_pkg::entry_t mem_reg [DEPTH];
    logic [AW:0] wptr_reg, wptr_next, rptr_reg, rptr_next;

    assign full       = (wptr_reg[AW] != rptr_reg[AW]) && (wptr_reg[AW-1:0] == rptr_reg[AW-1:0]);
    assign head_valid = wptr_reg != rptr_reg;
    assign head       = mem_reg[rptr_reg[AW-1:0]];
    assign wptr_next  = push ? wptr_reg + (AW+1)'(1) : wptr_reg;
    assign rptr_next  = pop ? rptr_reg + (AW+1)'(1) : rptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg[AW-1:0]] <= push_entry;
        end
    end

endmodule

/* rtl/core/ccpl_back.sv */
module ccpl_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  ccpl_pkg::entry_t              head,
    output logic                          pop,
    input  logic [ccpl_pkg::RUN_W-1:0]    left_run,
    input  logic [ccpl_pkg::RUN_W-1:0]    right_run,
    input  logic [ccpl_pkg::RUN_W-1:0]    top_run,
    input  logic [ccpl_pkg::RUN_W-1:0]    bottom_run,
    input  logic [ccpl_pkg::PIX_W-1:0]    fill_value,
    input  logic                          narrow_pixels,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ccpl_pkg::PIX_W-1:0]    out_value,
    output logic [ccpl_pkg::RUN_W-1:0]    run_length,
    output logic                          is_fill,
    output logic                          line_end,
    output logic                          frame_end,
    output logic                          last_of_step
);

    logic [ccpl_pkg::NUM_PARTS-1:0] done_reg, done_next, pend, sel;
    logic                           last, advance;
    logic [ccpl_pkg::PIX_W-1:0]     val, val_n;
    logic [ccpl_pkg::RUN_W-1:0]     run;
    logic                           fill_f, le_f, fe_f;

    logic                           out_valid_reg;
    logic [ccpl_pkg::PIX_W-1:0]     out_value_reg;
    logic [ccpl_pkg::RUN_W-1:0]     run_length_reg;
    logic                           is_fill_reg, line_end_reg, frame_end_reg, last_reg;

    always_comb
    begin
        pend    = head.parts & ~done_reg;
        sel     = pend & (~pend + ccpl_pkg::NUM_PARTS'(1));
        last    = (pend & ~sel) == '0;
        advance = head_valid && (!out_valid_reg || out_ready);
        pop     = advance && last;

        val    = fill_value;
        run    = bottom_run;
        fill_f = 1'b1;
        le_f   = 1'b1;
        fe_f   = 1'b1;
        if (sel[ccpl_pkg::PART_TOP])
        begin
            run  = top_run;
            fe_f = 1'b0;
        end
        else if (sel[ccpl_pkg::PART_LEFT])
        begin
            run  = left_run;
            le_f = 1'b0;
            fe_f = 1'b0;
        end
        else if (sel[ccpl_pkg::PART_COPY])
        begin
            val    = head.pixel;
            run    = ccpl_pkg::RUN_W'(1);
            fill_f = 1'b0;
            le_f   = head.copy_le;
            fe_f   = head.copy_fe;
        end
        else if (sel[ccpl_pkg::PART_RIGHT])
        begin
            run  = right_run;
            fe_f = head.right_fe;
        end
        val_n = narrow_pixels ? ccpl_pkg::PIX_W'(val[7:0]) : val;

        if (!advance)
            done_next = done_reg;
        else if (last)
            done_next = '0;
        else
            done_next = done_reg | sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_value_reg  <= val_n;
            run_length_reg <= run;
            is_fill_reg    <= fill_f;
            line_end_reg   <= le_f;
            frame_end_reg  <= fe_f;
            last_reg       <= last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_value    = out_value_reg;
    assign run_length   = run_length_reg;
    assign is_fill      = is_fill_reg;
    assign line_end     = line_end_reg;
    assign frame_end    = frame_end_reg;
    assign last_of_step = last_reg;

endmodule

/* rtl/core/center_crop_pad_letterbox_top.sv */
// Centers a raster-order source frame in a destination frame, cropping or padding each axis.
// s_axis carries one source pixel per item; m_axis carries one result per item: a copied
// pixel, or a fill run with its length. A source pixel yields up to five results in the
// order top, left, copy, right and bottom run; cropped pixels yield at most the bottom run.
// cfg_we/cfg_index/cfg_data write the six setup registers; the user must do so only while
// the block is idle, which the block itself does not enforce. Throughput: one item per cycle
// in and out while the queue has room and m_axis_tready is high; the result sequencer issues
// one result per cycle, so each extra pad run adds one more result on the output side.
// The front classifies pixels and the back issues results; a four-entry queue sits between
// them, so a short output stall does not stop the input at once.
// Pad run lengths are registered, not combinational, from the dimension registers.
// When m_axis_tready is low the output register holds its result, the queue fills, and then
// s_axis_tready drops; nothing is lost or repeated.
// Reset clears the raster position to the first pixel, empties the queue and output, and
// sets the dimensions to 1, fill to 0 and wide pixels.
module center_crop_pad_letterbox_top #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ccpl_pkg::PIX_W-1:0]          s_axis_tdata,  // pixel_value
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ccpl_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,  // out_value, run_length
    output logic [ccpl_pkg::TUSER_OUT_W-1:0]    m_axis_tuser,  // is_fill, line_end, last_of_step
    output logic                                m_axis_tlast,  // frame_end
    input  logic                                cfg_we,
    input  logic [ccpl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ccpl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int PAD = ccpl_pkg::TDATA_OUT_W - ccpl_pkg::PIX_W - ccpl_pkg::RUN_W;

    logic [DW-1:0] sw_cl, sh_cl, in_c, c_end, in_r, r_end, sw_last, sh_last;
    logic          top_nz, left_nz, right_nz, bottom_nz;
    logic [ccpl_pkg::RUN_W-1:0] left_run, right_run, top_run, bottom_run;
    logic [ccpl_pkg::PIX_W-1:0] fill_value;
    logic          narrow_pixels;

    logic             q_push, q_full, q_pop, q_valid;
    ccpl_pkg::entry_t q_entry, q_head;

    logic [ccpl_pkg::PIX_W-1:0] out_value;
    logic [ccpl_pkg::RUN_W-1:0] run_length;
    logic                       is_fill, line_end, frame_end, last_of_step;

    ccpl_geom #(.MAX_DIM(MAX_DIM)) u_geom (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sw_cl         (sw_cl),
        .sh_cl         (sh_cl),
        .in_c          (in_c),
        .c_end         (c_end),
        .in_r          (in_r),
        .r_end         (r_end),
        .sw_last       (sw_last),
        .sh_last       (sh_last),
        .top_nz        (top_nz),
        .left_nz       (left_nz),
        .right_nz      (right_nz),
        .bottom_nz     (bottom_nz),
        .left_run      (left_run),
        .right_run     (right_run),
        .top_run       (top_run),
        .bottom_run    (bottom_run),
        .fill_value    (fill_value),
        .narrow_pixels (narrow_pixels)
    );

    ccpl_front #(.MAX_DIM(MAX_DIM)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pixel  (s_axis_tdata),
        .sw_cl     (sw_cl),
        .sh_cl     (sh_cl),
        .in_c      (in_c),
        .c_end     (c_end),
        .in_r      (in_r),
        .r_end     (r_end),
        .sw_last   (sw_last),
        .sh_last   (sh_last),
        .top_nz    (top_nz),
        .left_nz   (left_nz),
        .right_nz  (right_nz),
        .bottom_nz (bottom_nz),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    ccpl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head)
    );

    ccpl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (q_valid),
        .head          (q_head),
        .pop           (q_pop),
        .left_run      (left_run),
        .right_run     (right_run),
        .top_run       (top_run),
        .bottom_run    (bottom_run),
        .fill_value    (fill_value),
        .narrow_pixels (narrow_pixels),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_value     (out_value),
        .run_length    (run_length),
        .is_fill       (is_fill),
        .line_end      (line_end),
        .frame_end     (frame_end),
        .last_of_step  (last_of_step)
    );

    assign m_axis_tdata = {{PAD{1'b0}}, run_length, out_value};
    assign m_axis_tuser = {last_of_step, line_end, is_fill};
    assign m_axis_tlast = frame_end;

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    a_copy_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !is_fill) |-> (run_length == ccpl_pkg::RUN_W'(1)))
        else $error("copied pixel with run length other than one");

    a_frame_end_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && frame_end) |-> (line_end && last_of_step))
        else $error("frame end without line end or before last result of item");

    a_pop_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (m_axis_tvalid && last_of_step))
        else $error("queue popped without issuing the last result of its item");
`endif

endmodule

/* verif/center_crop_pad_letterbox_top_tb.sv */
`timescale 1ns / 100ps

module center_crop_pad_letterbox_top_tb;

    localparam int DIM_LIMIT = 4096;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_ITEMS = 260;
    localparam int WIDE_LINE = 128;

    typedef struct packed {
        logic [ccpl_pkg::PIX_W-1:0] value;
        logic [ccpl_pkg::RUN_W-1:0] run;
        logic                       fill;
        logic                       line_end;
        logic                       frame_end;
        logic                       last;
    } result_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [ccpl_pkg::PIX_W-1:0]       s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [ccpl_pkg::TDATA_OUT_W-1:0] m_axis_tdata;
    logic [ccpl_pkg::TUSER_OUT_W-1:0] m_axis_tuser;
    logic                             m_axis_tlast;
    logic                             cfg_we = 1'b0;
    logic [ccpl_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [ccpl_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // shadow of the setup registers and the raster position
    logic [ccpl_pkg::CFG_DIM_W-1:0]   src_w_reg = 13'd1;
    logic [ccpl_pkg::CFG_DIM_W-1:0]   src_h_reg = 13'd1;
    logic [ccpl_pkg::CFG_DIM_W-1:0]   dst_w_reg = 13'd1;
    logic [ccpl_pkg::CFG_DIM_W-1:0]   dst_h_reg = 13'd1;
    logic [ccpl_pkg::PIX_W-1:0]       fill_reg = '0;
    logic                             narrow_reg = 1'b0;
    int unsigned                      pos_col = 0;
    int unsigned                      pos_row = 0;

    result_t                          pending_results[$];
    int                               mismatch_count = 0;
    bit                               no_idle = 1'b0;

    center_crop_pad_letterbox_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int unsigned fit_dim(input logic [ccpl_pkg::CFG_DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DIM_LIMIT)
            return DIM_LIMIT;
        return v;
    endfunction

    function automatic void push_result(input logic [ccpl_pkg::PIX_W-1:0] v,
                                        input int unsigned len,
                                        input bit f, input bit le, input bit fe);
        result_t r;
        r.value     = narrow_reg ? {24'd0, v[7:0]} : v;
        r.run       = len[ccpl_pkg::RUN_W-1:0];
        r.fill      = f;
        r.line_end  = le;
        r.frame_end = fe;
        r.last      = 1'b0;
        pending_results.push_back(r);
    endfunction

    task automatic predict_pixel(input logic [ccpl_pkg::PIX_W-1:0] pix);
        int unsigned sw, sh, tw, th, kc, kr, crop_c, crop_r;
        int unsigned left, top, right, bottom, c, r;
        bit row_kept, col_kept, last_kept_row, last_src, first_col, last_col, le;
        int size_before;
        result_t tail;
        sw = fit_dim(src_w_reg);
        sh = fit_dim(src_h_reg);
        tw = fit_dim(dst_w_reg);
        th = fit_dim(dst_h_reg);
        kc = (sw < tw) ? sw : tw;
        kr = (sh < th) ? sh : th;
        crop_c = (sw > tw) ? (sw - tw) / 2 : 0;
        crop_r = (sh > th) ? (sh - th) / 2 : 0;
        left = (tw > sw) ? (tw - sw) / 2 : 0;
        top = (th > sh) ? (th - sh) / 2 : 0;
        right = tw - left - kc;
        bottom = th - top - kr;
        c = pos_col;
        r = pos_row;
        row_kept = (r >= crop_r) && (r < crop_r + kr);
        col_kept = (c >= crop_c) && (c < crop_c + kc);
        last_kept_row = (r == crop_r + kr - 1);
        last_src = (r == sh - 1) && (c == sw - 1);
        size_before = pending_results.size();
        if (row_kept && col_kept)
        begin
            first_col = (c == crop_c);
            last_col = (c == crop_c + kc - 1);
            if (r == crop_r && first_col && top > 0)
                push_result(fill_reg, top * tw, 1'b1, 1'b1, 1'b0);
            if (first_col && left > 0)
                push_result(fill_reg, left, 1'b1, 1'b0, 1'b0);
            le = last_col && (right == 0);
            push_result(pix, 1, 1'b0, le, le && last_kept_row && (bottom == 0));
            if (last_col && right > 0)
                push_result(fill_reg, right, 1'b1, 1'b1, last_kept_row && (bottom == 0));
        end
        if (last_src && bottom > 0)
            push_result(fill_reg, bottom * tw, 1'b1, 1'b1, 1'b1);
        if (pending_results.size() > size_before)
        begin
            tail = pending_results.pop_back();
            tail.last = 1'b1;
            pending_results.push_back(tail);
        end
        if (c + 1 >= sw)
        begin
            pos_col = 0;
            pos_row = (r + 1 >= sh) ? 0 : r + 1;
        end
        else
            pos_col = c + 1;
    endtask

    task automatic send_pixel(input logic [ccpl_pkg::PIX_W-1:0] pix);
        while (!no_idle && $urandom_range(0, 99) < 7)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        predict_pixel(pix);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_random_pixels(input int count);
        for (int i = 0; i < count; i++)
            send_pixel($urandom);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input ccpl_pkg::cfg_reg_t idx,
                             input logic [ccpl_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            ccpl_pkg::REG_SOURCE_WIDTH:  src_w_reg = val[ccpl_pkg::CFG_DIM_W-1:0];
            ccpl_pkg::REG_SOURCE_HEIGHT: src_h_reg = val[ccpl_pkg::CFG_DIM_W-1:0];
            ccpl_pkg::REG_TARGET_WIDTH:  dst_w_reg = val[ccpl_pkg::CFG_DIM_W-1:0];
            ccpl_pkg::REG_TARGET_HEIGHT: dst_h_reg = val[ccpl_pkg::CFG_DIM_W-1:0];
            ccpl_pkg::REG_FILL_VALUE:    fill_reg = val;
            ccpl_pkg::REG_NARROW_PIXELS: narrow_reg = val[0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [ccpl_pkg::CFG_DATA_W-1:0] sw,
                                input logic [ccpl_pkg::CFG_DATA_W-1:0] sh,
                                input logic [ccpl_pkg::CFG_DATA_W-1:0] tw,
                                input logic [ccpl_pkg::CFG_DATA_W-1:0] th,
                                input logic [ccpl_pkg::CFG_DATA_W-1:0] fill,
                                input logic [ccpl_pkg::CFG_DATA_W-1:0] narrow);
        write_reg(ccpl_pkg::REG_SOURCE_WIDTH, sw);
        write_reg(ccpl_pkg::REG_SOURCE_HEIGHT, sh);
        write_reg(ccpl_pkg::REG_TARGET_WIDTH, tw);
        write_reg(ccpl_pkg::REG_TARGET_HEIGHT, th);
        write_reg(ccpl_pkg::REG_FILL_VALUE, fill);
        write_reg(ccpl_pkg::REG_NARROW_PIXELS, narrow);
        cfg_we <= 1'b0;
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.value     = m_axis_tdata[ccpl_pkg::PIX_W-1:0];
            got.run       = m_axis_tdata[ccpl_pkg::PIX_W +: ccpl_pkg::RUN_W];
            got.fill      = m_axis_tuser[ccpl_pkg::TU_IS_FILL];
            got.line_end  = m_axis_tuser[ccpl_pkg::TU_LINE_END];
            got.frame_end = m_axis_tlast;
            got.last      = m_axis_tuser[ccpl_pkg::TU_LAST];
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: value %h run %0d fill %b line %b frame %b last %b",
                             got.value, got.run, got.fill, got.line_end, got.frame_end,
                             got.last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch exp: value %h run %0d fill %b line %b frame %b last %b",
                                 want.value, want.run, want.fill, want.line_end,
                                 want.frame_end, want.last);
                        $display("         got: value %h run %0d fill %b line %b frame %b last %b",
                                 got.value, got.run, got.fill, got.line_end, got.frame_end,
                                 got.last);
                    end
                end
            end
        end
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 7);
    end

    task automatic test_reset_defaults();
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel($urandom);
    endtask

    // odd pad on both axes puts the extra pixel and line after the source
    task automatic test_letterbox_odd_pad();
        wait_idle();
        set_geometry(2, 2, 5, 5, 32'hFFFF_FFFF, 0);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        send_pixel(32'hA5A5_5A5A);
        send_pixel(32'h5A5A_A5A5);
    endtask

    task automatic test_center_crop();
        wait_idle();
        set_geometry(4, 1, 1, 1, 32'h0000_0000, 0);
        send_random_pixels(4);
    endtask

    // cropped width with padded height, narrow pixels
    task automatic test_crop_and_pad_narrow();
        wait_idle();
        set_geometry(3, 1, 1, 3, 32'h1234_5678, 1);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hDEAD_BEEF);
        send_pixel(32'h0000_0001);
    endtask

    // largest destination, and a height above the limit that acts as the limit
    task automatic test_largest_frame();
        wait_idle();
        set_geometry(1, 1, DIM_LIMIT, 32'hFFFF_FFFF, 32'h8000_0001, 0);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
    endtask

    task automatic test_zero_dims();
        wait_idle();
        set_geometry(0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_random_pixels(2);
    endtask

    task automatic test_wide_source_line();
        wait_idle();
        set_geometry(WIDE_LINE, 1, 3, 1, $urandom, 1);
        send_random_pixels(WIDE_LINE);
    endtask

    task automatic test_random_frames();
        int sent;
        int count;
        int unsigned frame;
        logic [ccpl_pkg::CFG_DATA_W-1:0] dims[4];
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            no_idle = (sent >= 90) && (sent < 200);
            for (int i = 0; i < 4; i++)
            begin
                dims[i] = $urandom_range(0, 9);
                if ($urandom_range(0, 1) == 1)
                    dims[i] = dims[i] | ($urandom & 32'hFFFF_E000);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                dims[2] = $urandom_range(1, DIM_LIMIT);
                dims[3] = $urandom_range(1, DIM_LIMIT);
            end
            set_geometry(dims[0], dims[1], dims[2], dims[3], $urandom, $urandom);
            frame = fit_dim(src_w_reg) * fit_dim(src_h_reg);
            if ($urandom_range(0, 9) == 0)
                count = $urandom_range(1, frame);
            else
                count = frame * $urandom_range(1, 2);
            send_random_pixels(count);
            sent += count;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_reset_defaults();
        test_letterbox_odd_pad();
        test_center_crop();
        test_crop_and_pad_narrow();
        test_largest_frame();
        test_zero_dims();
        test_wide_source_line();
        test_random_frames();
        wait_idle();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
